[design/c2p_pkg.sv]
package c2p_pkg;

  // default parameter values
  localparam int DEF_DATA_WIDTH = 16;
  localparam int DEF_ITERATIONS = 16;

  // fixed field widths
  localparam int IN_W  = 16;
  localparam int MAG_W = 16;
  localparam int ANG_W = 15;

  // fraction bits carried by the x and y datapath
  localparam int GUARD = 16;

  // angle accumulator: signed degrees in units of 2^-16 degree
  localparam int ZW       = 26;
  localparam int DEG_UNIT = 65536;

  // output angle units per degree
  localparam int OUT_PER_DEG = 64;

  // axis angles in output units
  localparam logic [ANG_W-1:0] ANG_0   = ANG_W'(0);
  localparam logic [ANG_W-1:0] ANG_90  = ANG_W'(90 * OUT_PER_DEG);
  localparam logic [ANG_W-1:0] ANG_180 = ANG_W'(180 * OUT_PER_DEG);
  localparam logic [ANG_W-1:0] ANG_270 = ANG_W'(270 * OUT_PER_DEG);
  localparam logic [ANG_W-1:0] ANGLE_WRAP = ANG_W'(360 * OUT_PER_DEG);

  // half and full turn in accumulator units
  localparam logic signed [ZW-1:0] Z_180 = ZW'(180 * DEG_UNIT);
  localparam logic signed [ZW-1:0] Z_360 = ZW'(360 * DEG_UNIT);

  // inverse cordic gain in Q30
  localparam logic [29:0] GAIN_Q30 = 30'h26DD3B6A;

  // control and bypass data that travels beside the datapath
  typedef struct packed {
    logic             valid;
    logic             axis;
    logic [MAG_W-1:0] mag;
    logic [ANG_W-1:0] ang;
  } ctrl_t;

  // atan(2^-i) in degrees, scaled by 2^16
  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] idx);
    logic [21:0] v;
    unique case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return $signed({{(ZW-22){1'b0}}, v});
  endfunction

endpackage

[design/cartesian_to_polar_degrees.sv]
// Cartesian to polar converter: magnitude and angle (0 to under 360 degrees,
// in 1/64 degree) of a signed complex sample, by a row of CORDIC vectoring
// cells. One item is taken every clock cycle: busy stays low, so start alone
// accepts an item. Each result passes one input stage, one cell per
// micro-rotation and two stages for the gain multiply and angle rounding,
// and is shown on magnitude and angle for the one cycle in which done is
// high. Results come in input order and cannot be held off, so the receiver
// must take them as they come. Axis samples and zero are answered exactly.
module cartesian_to_polar_degrees #(
  parameter int DATA_WIDTH = c2p_pkg::DEF_DATA_WIDTH,
  parameter int ITERATIONS = c2p_pkg::DEF_ITERATIONS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [c2p_pkg::IN_W-1:0]      real_in,
  input  logic [c2p_pkg::IN_W-1:0]      imag_in,
  output logic                          done,
  output logic [c2p_pkg::MAG_W-1:0]     magnitude,
  output logic [c2p_pkg::ANG_W-1:0]     angle
);
  import c2p_pkg::*;

  localparam int XW  = DATA_WIDTH + GUARD + 3;
  localparam int LAT = ITERATIONS + 3;

  logic signed [XW-1:0] x_s [ITERATIONS+1];
  logic signed [XW-1:0] y_s [ITERATIONS+1];
  logic signed [ZW-1:0] z_s [ITERATIONS+1];
  ctrl_t                c_s [ITERATIONS+1];

  // fully pipelined, never stalls
  assign busy = 1'b0;

  // operand fetch, axis detection and half-plane fold
  c2p_prep #(
    .DATA_WIDTH (DATA_WIDTH),
    .XW         (XW)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .real_in  (real_in),
    .imag_in  (imag_in),
    .x_out    (x_s[0]),
    .y_out    (y_s[0]),
    .z_out    (z_s[0]),
    .ctrl_out (c_s[0])
  );

  // row of micro-rotation cells
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    c2p_cell #(
      .XW    (XW),
      .SHIFT (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .x_in     (x_s[i]),
      .y_in     (y_s[i]),
      .z_in     (z_s[i]),
      .ctrl_in  (c_s[i]),
      .x_out    (x_s[i+1]),
      .y_out    (y_s[i+1]),
      .z_out    (z_s[i+1]),
      .ctrl_out (c_s[i+1])
    );
  end

  // gain compensation, angle rounding and output registers
  c2p_post #(
    .XW (XW)
  ) u_post (
    .clk       (clk),
    .rst       (rst),
    .x_in      (x_s[ITERATIONS]),
    .z_in      (z_s[ITERATIONS]),
    .ctrl_in   (c_s[ITERATIONS]),
    .done      (done),
    .magnitude (magnitude),
    .angle     (angle)
  );

  // every accepted item comes out as a done pulse
  a_item_out: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done)
    else $error("accepted item did not produce a result");

  // no result without an accepted item
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without an accepted item");

  // angle stays below a full turn
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (angle < ANGLE_WRAP))
    else $error("angle out of range");

endmodule

[design/c2p_prep.sv]
module c2p_prep #(
  parameter int DATA_WIDTH = c2p_pkg::DEF_DATA_WIDTH,
  parameter int XW         = c2p_pkg::DEF_DATA_WIDTH + c2p_pkg::GUARD + 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [c2p_pkg::IN_W-1:0]      real_in,
  input  logic [c2p_pkg::IN_W-1:0]      imag_in,
  output logic signed [XW-1:0]          x_out,
  output logic signed [XW-1:0]          y_out,
  output logic signed [c2p_pkg::ZW-1:0] z_out,
  output c2p_pkg::ctrl_t                ctrl_out
);
  import c2p_pkg::*;

  localparam int DW = DATA_WIDTH;

  logic [DW+IN_W-1:0]    ext_x;
  logic [DW+IN_W-1:0]    ext_y;
  logic signed [DW-1:0]  op_x;
  logic signed [DW-1:0]  op_y;
  logic                  x_zero;
  logic                  y_zero;
  logic [DW-1:0]         abs_x;
  logic [DW-1:0]         abs_y;
  logic [DW+MAG_W-1:0]   abs_ext;
  logic [MAG_W-1:0]      axis_mag;
  logic [ANG_W-1:0]      axis_ang;
  logic signed [DW:0]    xw;
  logic signed [DW:0]    yw;
  logic signed [DW:0]    x_rot;
  logic signed [DW:0]    y_rot;

  // operands are the low bits of each field, zero above the field
  assign ext_x = {{DW{1'b0}}, real_in};
  assign ext_y = {{DW{1'b0}}, imag_in};
  assign op_x  = $signed(ext_x[DW-1:0]);
  assign op_y  = $signed(ext_y[DW-1:0]);

  assign x_zero = (op_x == '0);
  assign y_zero = (op_y == '0);

  // exact answers on the axes
  assign abs_x = op_x[DW-1] ? DW'(-op_x) : DW'(op_x);
  assign abs_y = op_y[DW-1] ? DW'(-op_y) : DW'(op_y);

  always_comb begin
    if (y_zero) begin
      abs_ext  = {{MAG_W{1'b0}}, abs_x};
      axis_ang = op_x[DW-1] ? ANG_180 : ANG_0;
    end else begin
      abs_ext  = {{MAG_W{1'b0}}, abs_y};
      axis_ang = op_y[DW-1] ? ANG_270 : ANG_90;
    end
    axis_mag = (|abs_ext[DW+MAG_W-1:MAG_W]) ? {MAG_W{1'b1}} : abs_ext[MAG_W-1:0];
  end

  // fold the left half plane into the right one
  assign xw    = {op_x[DW-1], op_x};
  assign yw    = {op_y[DW-1], op_y};
  assign x_rot = op_x[DW-1] ? -xw : xw;
  assign y_rot = op_x[DW-1] ? -yw : yw;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else begin
      ctrl_out.valid <= start;
      ctrl_out.axis  <= x_zero | y_zero;
      ctrl_out.mag   <= axis_mag;
      ctrl_out.ang   <= axis_ang;
    end
  end

  // scaled operands and starting angle
  always_ff @(posedge clk) begin
    x_out <= {{(XW-DW-1-GUARD){x_rot[DW]}}, x_rot, {GUARD{1'b0}}};
    y_out <= {{(XW-DW-1-GUARD){y_rot[DW]}}, y_rot, {GUARD{1'b0}}};
    z_out <= op_x[DW-1] ? Z_180 : '0;
  end

endmodule

[design/c2p_cell.sv]
module c2p_cell #(
  parameter int XW    = c2p_pkg::DEF_DATA_WIDTH + c2p_pkg::GUARD + 3,
  parameter int SHIFT = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [XW-1:0]          x_in,
  input  logic signed [XW-1:0]          y_in,
  input  logic signed [c2p_pkg::ZW-1:0] z_in,
  input  c2p_pkg::ctrl_t                ctrl_in,
  output logic signed [XW-1:0]          x_out,
  output logic signed [XW-1:0]          y_out,
  output logic signed [c2p_pkg::ZW-1:0] z_out,
  output c2p_pkg::ctrl_t                ctrl_out
);
  import c2p_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = atan_deg(5'(SHIFT));

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  // arithmetic shifts floor toward minus infinity
  assign xs = x_in >>> SHIFT;
  assign ys = y_in >>> SHIFT;

  // one micro-rotation toward the real axis
  always_ff @(posedge clk) begin
    if (!y_in[XW-1]) begin
      x_out <= x_in + ys;
      y_out <= y_in - xs;
      z_out <= z_in + ATAN;
    end else begin
      x_out <= x_in - ys;
      y_out <= y_in + xs;
      z_out <= z_in - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else begin
      ctrl_out <= ctrl_in;
    end
  end

endmodule

[design/c2p_post.sv]
module c2p_post #(
  parameter int XW = c2p_pkg::DEF_DATA_WIDTH + c2p_pkg::GUARD + 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [XW-1:0]          x_in,
  input  logic signed [c2p_pkg::ZW-1:0] z_in,
  input  c2p_pkg::ctrl_t                ctrl_in,
  output logic                          done,
  output logic [c2p_pkg::MAG_W-1:0]     magnitude,
  output logic [c2p_pkg::ANG_W-1:0]     angle
);
  import c2p_pkg::*;

  // gain multiply split in two halves of the non-negative x
  localparam int LO = (XW - 1) / 2;
  localparam int HI = XW - 1 - LO;
  localparam int SW = (XW + 31 > 64) ? XW + 31 : 64;
  localparam logic [SW-1:0] MAG_RND = {{(SW-46){1'b0}}, 1'b1, {45{1'b0}}};
  localparam logic [ZW-2:0] ANG_RND = (ZW-1)'(512);

  logic [XW-2:0]  x_pos;
  logic [ZW-2:0]  z_adj;
  logic [LO+29:0] p_lo;
  logic [HI+29:0] p_hi;
  logic [ZW-2:0]  z_hold;
  ctrl_t          ctrl_mid;
  logic [SW-1:0]  mag_sum;
  logic [ZW-2:0]  z_rnd;
  logic [ANG_W-1:0] ang_raw;
  logic [ANG_W-1:0] ang_fin;
  logic [MAG_W-1:0] mag_fin;

  // clamp x at zero, bring a negative angle into range
  assign x_pos = x_in[XW-1] ? '0 : x_in[XW-2:0];
  always_comb begin
    if (z_in[ZW-1]) begin
      z_adj = (ZW-1)'(z_in + Z_360);
    end else begin
      z_adj = z_in[ZW-2:0];
    end
  end

  // partial products
  always_ff @(posedge clk) begin
    p_lo   <= (LO+30)'(x_pos[LO-1:0]) * (LO+30)'(GAIN_Q30);
    p_hi   <= (HI+30)'(x_pos[XW-2:LO]) * (HI+30)'(GAIN_Q30);
    z_hold <= z_adj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_mid <= '0;
    end else begin
      ctrl_mid <= ctrl_in;
    end
  end

  // sum and round the magnitude, saturate to the output width
  assign mag_sum = (SW'(p_hi) << LO) + SW'(p_lo) + MAG_RND;
  assign mag_fin = (|mag_sum[SW-1:46+MAG_W]) ? {MAG_W{1'b1}} : mag_sum[46+MAG_W-1:46];

  // round the angle to 1/64 degree and wrap a full turn
  assign z_rnd   = z_hold + ANG_RND;
  assign ang_raw = z_rnd[ZW-2:10];
  assign ang_fin = (ang_raw >= ANGLE_WRAP) ? ang_raw - ANGLE_WRAP : ang_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_mid.valid;
    end
  end

  always_ff @(posedge clk) begin
    magnitude <= ctrl_mid.axis ? ctrl_mid.mag : mag_fin;
    angle     <= ctrl_mid.axis ? ctrl_mid.ang : ang_fin;
  end

endmodule
